@@ rtl/core/ffa_pkg.sv @@
// Package for the first-fit free list allocator.
// Holds status codes, action codes and the cell control struct; no dependencies.
package ffa_pkg;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_OOM     = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	// Operation broadcast to every cell for one update cycle.
	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_MERGE  = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] addr;
		logic [31:0] bytes;
	} ffa_cmd_t;

endpackage

@@ rtl/core/first_fit_free_list_allocator.sv @@
// Top level of the first-fit free list allocator: sequencer, bump pointer
// and the chain of ffa_cell entries. Depends on ffa_pkg and ffa_cell.
//
// A request passes through the states idle, size, decide and update. The request
// is registered at the edge that accepts start in idle. The size state sizes the
// request while the cells compare their addresses with the header of a free. The
// decide state compares the cell sizes with the rounded total and registers the
// result. In the update state, done is high and every cell shifts or loads in
// parallel. busy is high in size, decide and update, so the next start is taken
// in the cycle after done, and not before. Results appear for one cycle with done
// high and must be taken then: the receiver cannot stall the block. A free
// into a full table reports status 3 unless it merges with the following entry.
module first_fit_free_list_allocator #(
	parameter int FREE_ENTRIES = 64,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [24:0] request_size,
	input  logic [31:0] block_address,
	input  logic [31:0] block_bytes,
	output logic        done,
	output logic [31:0] granted_address,
	output logic [31:0] granted_bytes,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int N = FREE_ENTRIES;
	localparam logic [31:0] HDR = 32'(HEADER_BYTES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SIZE = 2'd1;
	localparam logic [1:0] S_DEC  = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0]  state_q;
	logic        act_q;
	logic [24:0] req_q;
	logic [31:0] hdr_q, size_q, need_q;
	logic [31:0] base_q, limit_q, bump_q;
	logic        loaded_q;
	logic [$clog2(N+1)-1:0] cnt_q;
	logic        done_q;
	logic [31:0] gaddr_q, gbytes_q;
	logic [1:0]  stat_q;
	ffa_pkg::ffa_cmd_t cmd;
	logic [1:0]  op_q;

	logic [N:0]  c_lt, c_fit, c_valid;
	logic [31:0] c_addr [N+1];
	logic [31:0] c_bytes[N+1];
	logic [N-1:0] at_pos_v, fit_v;
	logic        any_fit, merge_q, full_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign granted_address = gaddr_q;
	assign granted_bytes   = gbytes_q;
	assign status = stat_q;

	assign cmd.op    = op_q;
	assign cmd.addr  = hdr_q;
	assign cmd.bytes = size_q;

	assign c_lt[0] = 1'b1;
	assign c_fit[0] = 1'b0;
	assign c_valid[0] = 1'b0;
	assign c_addr[0] = 32'd0;
	assign c_bytes[0] = 32'd0;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			logic nv;
			logic [31:0] na, nb;
			if (g == N-1) begin : g_last
				assign nv = 1'b0;
				assign na = 32'd0;
				assign nb = 32'd0;
			end else begin : g_mid
				assign nv = c_valid[g+2];
				assign na = c_addr[g+2];
				assign nb = c_bytes[g+2];
			end
			ffa_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd),
				.cnt_ok(cnt_q > g), .prev_lt(c_lt[g]), .prev_fit(c_fit[g]),
				.prev_valid(c_valid[g]), .next_valid(nv),
				.prev_addr(c_addr[g]), .prev_bytes(c_bytes[g]),
				.next_addr(na), .next_bytes(nb), .need(need_q),
				.valid(c_valid[g+1]), .lt(c_lt[g+1]), .fit(c_fit[g+1]),
				.addr(c_addr[g+1]), .bytes(c_bytes[g+1])
			);
			assign at_pos_v[g] = c_lt[g] && !c_lt[g+1];
			assign fit_v[g]    = !c_fit[g] && c_fit[g+1];
		end
	endgenerate

	assign any_fit = c_fit[N];

	// One-hot selects of the fitting entry and the insert position.
	logic [31:0] sel_fa, sel_fb, pos_a, pos_b;
	logic        pos_v;
	always_comb begin
		sel_fa = '0; sel_fb = '0; pos_a = '0; pos_b = '0; pos_v = 1'b0;
		for (int k = 0; k < N; k++) begin
			sel_fa |= fit_v[k] ? c_addr[k+1] : 32'd0;
			sel_fb |= fit_v[k] ? c_bytes[k+1] : 32'd0;
			pos_a  |= at_pos_v[k] ? c_addr[k+1] : 32'd0;
			pos_b  |= at_pos_v[k] ? c_bytes[k+1] : 32'd0;
			pos_v  |= at_pos_v[k] && c_valid[k+1] && (cnt_q > k);
		end
	end

	logic [25:0] rq;
	logic [32:0] tot;
	logic [32:0] msum;
	always_comb begin
		rq  = (req_q == 25'd0) ? 26'd1 : {1'b0, req_q};
		tot = ({7'd0, rq} + 33'(HDR) + 33'd15) & ~33'd15;
		if (tot < 33'd32) tot = 33'd32;
		msum = {1'b0, size_q} + {1'b0, pos_b};
	end

	logic [31:0] bp;
	assign bp = loaded_q ? bump_q : base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; done_q <= 1'b0; cnt_q <= '0; op_q <= ffa_pkg::OP_HOLD;
			loaded_q <= 1'b0; base_q <= '0; limit_q <= '0;
		end else begin
			done_q <= 1'b0;
			op_q <= ffa_pkg::OP_HOLD;
			if (cfg_we) begin
				if (cfg_index == ffa_pkg::CFG_HEAP_BASE) base_q <= cfg_data;
				else limit_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_SIZE;
				S_SIZE: state_q <= S_DEC;
				S_DEC: begin
					state_q <= S_UPD;
					done_q  <= 1'b1;
					if (act_q == ffa_pkg::ACT_ALLOC) begin
						if (any_fit) begin
							op_q <= ffa_pkg::OP_REMOVE;
							cnt_q <= cnt_q - 1'b1;
						end else begin
							loaded_q <= 1'b1;
						end
					end else if (stat_q == ffa_pkg::ST_DONE) begin
						if (merge_q) op_q <= ffa_pkg::OP_MERGE;
						else if (!full_q) begin
							op_q <= ffa_pkg::OP_INSERT;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_UPD: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) begin
				act_q  <= action;
				req_q  <= request_size;
				hdr_q  <= block_address - HDR;
				size_q <= block_bytes;
				stat_q <= (block_address == 32'd0 || block_bytes == 32'd0)
					? ffa_pkg::ST_IGNORED : ffa_pkg::ST_DONE;
			end
			S_SIZE: begin
				need_q      <= (tot[32]) ? 32'hFFFF_FFFF : tot[31:0];
				// A total beyond 32 bits fits nothing; req width keeps it below.
			end
			S_DEC: begin
				if (act_q == ffa_pkg::ACT_ALLOC) begin
					if (any_fit) begin
						gaddr_q <= sel_fa + HDR;
						gbytes_q <= sel_fb;
						stat_q <= ffa_pkg::ST_DONE;
					end else if (bp > limit_q || (limit_q - bp) < need_q) begin
						gaddr_q <= '0; gbytes_q <= '0; stat_q <= ffa_pkg::ST_OOM;
						bump_q <= bp;
					end else begin
						gaddr_q <= bp + HDR; gbytes_q <= need_q;
						stat_q <= ffa_pkg::ST_DONE;
						bump_q <= bp + need_q;
					end
				end else begin
					gaddr_q <= '0; gbytes_q <= '0;
					if (stat_q == ffa_pkg::ST_DONE && !merge_q && full_q)
						stat_q <= ffa_pkg::ST_FULL;
				end
			end
			default: ;
		endcase
	end

	// The address compare of a free is registered at the end of the sizing
	// cycle; the size compare is used directly in the decision cycle, once
	// need_q holds the rounded total.
	always_ff @(posedge clk) begin
		if (state_q == S_SIZE) begin
			merge_q <= pos_v && (pos_a == hdr_q + size_q) && !msum[32];
			full_q  <= (cnt_q == ($clog2(N+1))'(N));
		end
	end
endmodule

@@ rtl/core/ffa_cell.sv @@
// One entry of the free table, kept in address order along the chain.
// Depends on ffa_pkg for the command struct.
module ffa_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ffa_pkg::ffa_cmd_t cmd,
	input  logic            cnt_ok,      // this entry is below the count
	input  logic            prev_lt,     // previous entry is below the header
	input  logic            prev_fit,    // some earlier entry fits
	input  logic            prev_valid,
	input  logic            next_valid,
	input  logic [31:0]     prev_addr,
	input  logic [31:0]     prev_bytes,
	input  logic [31:0]     next_addr,
	input  logic [31:0]     next_bytes,
	input  logic [31:0]     need,
	output logic            valid,
	output logic            lt,
	output logic            fit,
	output logic [31:0]     addr,
	output logic [31:0]     bytes
);
	logic [31:0] addr_q, bytes_q;
	logic        v_q;
	logic        at_pos, here_fit, removing, shifting;

	assign valid = v_q;
	assign addr  = addr_q;
	assign bytes = bytes_q;
	// Position of an insert is the first entry that is invalid, past the count or not below the header.
	assign lt    = prev_lt && v_q && cnt_ok && (addr_q < cmd.addr);
	assign here_fit = v_q && (bytes_q >= need);
	assign fit   = prev_fit || here_fit;
	assign at_pos   = prev_lt && !lt;
	assign removing = prev_fit;
	assign shifting = !prev_lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				ffa_pkg::OP_REMOVE: if (removing || here_fit) v_q <= next_valid;
				ffa_pkg::OP_INSERT: if (at_pos) v_q <= 1'b1;
					else if (shifting) v_q <= prev_valid;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ffa_pkg::OP_REMOVE: if (removing || here_fit) begin
				addr_q  <= next_addr;
				bytes_q <= next_bytes;
			end
			ffa_pkg::OP_INSERT: if (at_pos) begin
				addr_q  <= cmd.addr;
				bytes_q <= cmd.bytes;
			end else if (shifting) begin
				addr_q  <= prev_addr;
				bytes_q <= prev_bytes;
			end
			ffa_pkg::OP_MERGE: if (at_pos) begin
				addr_q  <= cmd.addr;
				bytes_q <= cmd.bytes + bytes_q;
			end
			default: ;
		endcase
	end
endmodule

@@ rtl/core/ffa_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
// Depends on ffa_pkg for status codes.
module ffa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] granted_address,
	input logic [31:0] granted_bytes,
	input logic [1:0]  status
);
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted start did not raise busy");
	a_done_three: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##2 done) else $error("result not on third cycle");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ffa_pkg::ST_DONE |-> granted_address == 32'd0
		&& granted_bytes == 32'd0) else $error("failed result not zero");
endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.granted_address(granted_address),
	.granted_bytes(granted_bytes), .status(status)
);

@@ tb/sv/first_fit_free_list_allocator_tb.sv @@
// Self-checking testbench for first_fit_free_list_allocator: directed and random
// allocate/free requests checked against an in-bench first-fit table predictor.
// Depends on ffa_pkg and the allocator RTL.
module first_fit_free_list_allocator_tb;

	localparam int TABLE_DEPTH = 64;
	localparam int HDR = 16;

	typedef struct {
		bit          is_cfg;
		logic        cidx;
		logic [31:0] cval;
		logic        act;
		logic [24:0] req;
		logic [31:0] baddr;
		logic [31:0] bbytes;
	} job_t;

	typedef struct {
		logic [31:0] addr;
		logic [31:0] bytes;
		logic [1:0]  st;
	} grant_t;

	logic clk, arst_n, start, busy, action, done, cfg_we, cfg_index;
	logic [24:0] request_size;
	logic [31:0] block_address, block_bytes, granted_address, granted_bytes, cfg_data;
	logic [1:0] status;

	job_t   job_q[$];
	grant_t grant_q[$];
	int     errors = 0;
	int     gap = 0;
	bit     taken = 0;

	// Shadow copy of the allocator state.
	logic [31:0] heap_base_r, heap_limit_r, bump_ptr;
	bit          bump_loaded;
	logic [31:0] ent_addr[TABLE_DEPTH];
	logic [31:0] ent_bytes[TABLE_DEPTH];
	int          ent_count;

	first_fit_free_list_allocator dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < ent_count; i++) begin
			ent_addr[i] = ent_addr[i + 1];
			ent_bytes[i] = ent_bytes[i + 1];
		end
		ent_count--;
	endfunction

	function automatic grant_t allocate_block(logic [24:0] req);
		grant_t g;
		logic [63:0] total;
		total = (req == 0) ? 64'd1 : 64'(req);
		total = (total + HDR + 15) & ~64'd15;
		if (total < 32) total = 32;
		g = '{32'd0, 32'd0, ffa_pkg::ST_DONE};
		for (int i = 0; i < ent_count; i++) begin
			if (64'(ent_bytes[i]) >= total) begin
				g.addr = ent_addr[i] + HDR;
				g.bytes = ent_bytes[i];
				drop_entry(i);
				return g;
			end
		end
		if (!bump_loaded) begin
			bump_ptr = heap_base_r;
			bump_loaded = 1;
		end
		if (bump_ptr > heap_limit_r || 64'(heap_limit_r - bump_ptr) < total) begin
			g.st = ffa_pkg::ST_OOM;
			return g;
		end
		g.addr = bump_ptr + HDR;
		g.bytes = total[31:0];
		bump_ptr = bump_ptr + total[31:0];
		return g;
	endfunction

	function automatic logic [1:0] release_block(logic [31:0] uaddr, logic [31:0] size);
		logic [31:0] hdr;
		int pos;
		if (uaddr == 0 || size == 0) return ffa_pkg::ST_IGNORED;
		hdr = uaddr - HDR;
		pos = 0;
		while (pos < ent_count && ent_addr[pos] < hdr) pos++;
		if (pos < ent_count && ent_addr[pos] == hdr + size &&
				33'(size) + 33'(ent_bytes[pos]) <= 33'hFFFFFFFF) begin
			ent_bytes[pos] = size + ent_bytes[pos];
			ent_addr[pos] = hdr;
			return ffa_pkg::ST_DONE;
		end
		if (ent_count >= TABLE_DEPTH) return ffa_pkg::ST_FULL;
		for (int i = ent_count; i > pos; i--) begin
			ent_addr[i] = ent_addr[i - 1];
			ent_bytes[i] = ent_bytes[i - 1];
		end
		ent_addr[pos] = hdr;
		ent_bytes[pos] = size;
		ent_count++;
		return ffa_pkg::ST_DONE;
	endfunction

	// Driver: inputs change on the falling edge only.
	always @(negedge clk) begin
		logic n_start, n_we;
		n_start = start;
		n_we = 0;
		if (!arst_n) begin
			n_start = 0;
		end else if (start && !taken) begin
			n_start = 1;
		end else if (gap > 0) begin
			gap--;
			n_start = 0;
		end else if (job_q.size() > 0 && !job_q[0].is_cfg) begin
			action <= job_q[0].act;
			request_size <= job_q[0].req;
			block_address <= job_q[0].baddr;
			block_bytes <= job_q[0].bbytes;
			void'(job_q.pop_front());
			n_start = 1;
			if ($urandom_range(0, 9) < 5) gap = 0;
			else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
			else gap = $urandom_range(8, 40);
		end else begin
			n_start = 0;
			// Registers change only once every result has come back.
			if (job_q.size() > 0 && grant_q.size() == 0 && !busy && !start) begin
				cfg_index <= job_q[0].cidx;
				cfg_data <= job_q[0].cval;
				void'(job_q.pop_front());
				n_we = 1;
			end
		end
		start <= n_start;
		cfg_we <= n_we;
	end

	// Monitor: predicts on each accepted transfer and checks each strobed result.
	always @(posedge clk) begin
		grant_t g;
		taken <= start && !busy;
		if (arst_n && cfg_we) begin
			if (cfg_index == ffa_pkg::CFG_HEAP_BASE) heap_base_r = cfg_data;
			else heap_limit_r = cfg_data;
		end
		if (arst_n && start && !busy) begin
			if (action == ffa_pkg::ACT_ALLOC) begin
				g = allocate_block(request_size);
			end else begin
				g = '{32'd0, 32'd0, ffa_pkg::ST_DONE};
				g.st = release_block(block_address, block_bytes);
			end
			grant_q.push_back(g);
		end
		if (arst_n && done) begin
			if (grant_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: addr %h bytes %h status %0d",
					granted_address, granted_bytes, status);
			end else begin
				g = grant_q.pop_front();
				if (g.addr !== granted_address || g.bytes !== granted_bytes ||
						g.st !== status) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h/%h/%0d, got %h/%h/%0d",
							g.addr, g.bytes, g.st, granted_address, granted_bytes, status);
				end
			end
		end
	end

	task automatic push_cfg(logic idx, logic [31:0] val);
		job_q.push_back('{1'b1, idx, val, ffa_pkg::ACT_ALLOC, 25'd0, 32'd0, 32'd0});
	endtask

	task automatic push_alloc(logic [24:0] req);
		job_q.push_back('{1'b0, ffa_pkg::CFG_HEAP_BASE, 32'd0, ffa_pkg::ACT_ALLOC, req,
			$urandom, $urandom});
	endtask

	task automatic push_free(logic [31:0] a, logic [31:0] b);
		job_q.push_back('{1'b0, ffa_pkg::CFG_HEAP_BASE, 32'd0, ffa_pkg::ACT_FREE,
			25'($urandom), a, b});
	endtask

	initial begin
		int n;
		logic [31:0] a, sz;
		start = 0; cfg_we = 0; cfg_index = ffa_pkg::CFG_HEAP_BASE; cfg_data = 0;
		action = ffa_pkg::ACT_ALLOC; request_size = 0; block_address = 0; block_bytes = 0;
		heap_base_r = 0; heap_limit_r = 0; bump_ptr = 0; bump_loaded = 0; ent_count = 0;
		arst_n = 0;

		// Directed part: sizes at the edges, null and zero frees, wrap and merge cases.
		push_cfg(ffa_pkg::CFG_HEAP_BASE, 32'h0000_1000);
		push_cfg(ffa_pkg::CFG_HEAP_LIMIT, 32'h0000_1400);
		push_alloc(25'd0);
		push_alloc(25'd1);
		push_alloc(25'd16);
		push_alloc(25'd17);
		push_alloc(25'd16777216);
		push_alloc(25'h1FFFFFF);
		push_free(32'd0, 32'd32);
		push_free(32'h0000_1010, 32'd0);
		push_free(32'h0000_1030, 32'd32);
		push_free(32'h0000_1010, 32'd32);
		push_alloc(25'd40);
		push_free(32'd8, 32'd32);
		push_free(32'hFFFF_FF10, 32'h200);
		push_free(32'h0000_0030, 32'hFFFF_FEE0);
		push_alloc(25'd100);
		push_alloc(25'd100);
		push_alloc(25'd900);
		push_alloc(25'd900);
		for (int i = 0; i < 8; i++) push_alloc(25'd48);

		// Late base write leaves the bump pointer where it is; extreme limits.
		push_cfg(ffa_pkg::CFG_HEAP_BASE, 32'hFFFF_FF00);
		push_cfg(ffa_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++) push_alloc(25'($urandom_range(0, 64)));

		// Fill the table with separated blocks, overflow it, then merge into a follower.
		for (int i = 0; i < TABLE_DEPTH + 3; i++)
			push_free(32'h4000_0010 + i * 32'h100, 32'h20);
		push_free(32'h4000_00F0, 32'h20);
		for (int i = 0; i < 6; i++) push_alloc(25'd16);

		n = 0;
		while (n < 300) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						push_cfg(ffa_pkg::CFG_HEAP_BASE, 32'd0);
						push_cfg(ffa_pkg::CFG_HEAP_LIMIT, 32'd0);
					end
					1: begin
						push_cfg(ffa_pkg::CFG_HEAP_BASE, 32'd0);
						push_cfg(ffa_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
					end
					2: begin
						push_cfg(ffa_pkg::CFG_HEAP_BASE, 32'h8000_0000);
						push_cfg(ffa_pkg::CFG_HEAP_LIMIT, 32'h1000);
					end
					default: begin
						push_cfg(ffa_pkg::CFG_HEAP_BASE, $urandom);
						push_cfg(ffa_pkg::CFG_HEAP_LIMIT, $urandom);
					end
				endcase
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					if ($urandom_range(0, 9) < 8) push_alloc(25'($urandom_range(0, 300)));
					else push_alloc(25'($urandom));
					n++;
				end
				4, 5, 6: begin
					// A chain of blocks given back highest first, so each one after the first merges.
					a = 32'h1000_0000 + $urandom_range(0, 4095) * 16;
					for (int k = $urandom_range(1, 4); k > 0; k--) begin
						sz = $urandom_range(2, 8) * 16;
						a = a - sz;
						push_free(a + HDR, sz);
						n++;
					end
				end
				7, 8: begin
					push_free(32'h2000_0010 + $urandom_range(0, 65535) * 16,
						$urandom_range(2, 16) * 16);
					n++;
				end
				default: begin
					push_free(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
						($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
					n++;
				end
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		wait (job_q.size() == 0 && grant_q.size() == 0 && !start && !busy);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("first_fit_free_list_allocator verification clean");
		end else begin
			$display("first_fit_free_list_allocator verification failed");
		end
		$finish;
	end

	// A result still outstanding at the end also counts as a failure.
	always @(posedge clk) begin
		if (arst_n && job_q.size() == 0 && !start && !busy && !done && grant_q.size() > 0
				&& !taken) begin
			errors++;
			if (errors <= 10) $display("result missing for an accepted transfer");
			void'(grant_q.pop_front());
		end
	end

	initial begin
		#5000000;
		$display("first_fit_free_list_allocator verification failed");
		$finish;
	end

endmodule
